### rtl/mrsp_pkg.sv
// Package for the MIDI running-status parser.
// Holds the byte codes, the message and step types and the length decode.
// No dependencies.
`default_nettype none

package mrsp_pkg;

  // Status byte codes.
  localparam logic [7:0] RealtimeFirst = 8'hF8;
  localparam logic [7:0] SysexStart    = 8'hF0;
  localparam logic [7:0] SysexEnd      = 8'hF7;
  localparam logic [7:0] SysCommonLow  = 8'hF1;
  localparam logic [7:0] SongPosition  = 8'hF2;
  localparam logic [7:0] SongSelect    = 8'hF3;
  localparam logic [7:0] StatusFlag    = 8'h80;
  localparam logic [3:0] NibProgram    = 4'hC;
  localparam logic [3:0] NibPressure   = 4'hD;
  localparam logic [3:0] NibSystem     = 4'hF;

  // Message lengths in bytes, status included.
  localparam logic [1:0] LenOne   = 2'd1;
  localparam logic [1:0] LenTwo   = 2'd2;
  localparam logic [1:0] LenThree = 2'd3;

  // One complete message.
  typedef struct packed {
    logic [1:0] msg_len;
    logic [7:0] msg_status;
    logic [6:0] msg_data1;
    logic [6:0] msg_data2;
  } msg_t;

  // One byte handed from the input register to the parser.
  typedef struct packed {
    logic       fire;
    logic [7:0] rx_byte;
  } step_t;

  // Number of data bytes that follow a status byte.
  function automatic logic [1:0] data_count(input logic [7:0] st);
    logic [1:0] cnt;
    cnt = 2'd2;
    if (st >= RealtimeFirst) begin
      cnt = 2'd0;
    end else begin
      case (st[7:4])
        NibProgram, NibPressure: cnt = 2'd1;
        NibSystem: begin
          if (st == SysCommonLow || st == SongSelect) begin
            cnt = 2'd1;
          end else if (st == SongPosition) begin
            cnt = 2'd2;
          end else begin
            cnt = 2'd0;
          end
        end
        default: cnt = 2'd2;
      endcase
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

### rtl/mrsp_if.sv
// Valid/ready channel interfaces for the MIDI parser: byte input and message output.
// No dependencies; the message fields are carried one by one.
`default_nettype none

interface mrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrsp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] msg_len;
  logic [7:0] msg_status;
  logic [6:0] msg_data1;
  logic [6:0] msg_data2;

  modport source (output valid, output msg_len, output msg_status,
                  output msg_data1, output msg_data2, input ready);
  modport sink   (input valid, input msg_len, input msg_status,
                  input msg_data1, input msg_data2, output ready);
endinterface

`default_nettype wire

### rtl/mrsp_in_reg.sv
// Input register of the MIDI parser: holds one received byte until the parser takes it.
// Depends on mrsp_pkg for the step type.
`default_nettype none

module mrsp_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_byte,
  output logic               in_ready,
  input  wire logic          out_space,
  output mrsp_pkg::step_t    step
);

  logic       full_r;
  logic       full_nxt;
  logic [7:0] byte_r;
  logic       advance;
  logic       take;

  // The held byte moves on whenever the result register has room.
  assign advance  = full_r && out_space;
  assign in_ready = !full_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    full_nxt = full_r;
    if (take) begin
      full_nxt = 1'b1;
    end else if (advance) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
    end
  end

  assign step.fire    = advance;
  assign step.rx_byte = byte_r;

endmodule

`default_nettype wire

### rtl/mrsp_parser.sv
// Parse state and decode of the MIDI parser: one byte per step, at most one message out.
// Depends on mrsp_pkg for codes, types and the length decode.
`default_nettype none

module mrsp_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mrsp_pkg::step_t  step,
  output logic                  res_valid,
  output mrsp_pkg::msg_t        res_msg
);

  logic [7:0] run_r,   run_nxt;
  logic [7:0] open_r,  open_nxt;
  logic [6:0] held_r,  held_nxt;
  logic [1:0] nheld_r, nheld_nxt;
  logic [1:0] nexp_r,  nexp_nxt;

  logic [7:0] b;
  logic [7:0] st;
  logic [1:0] cnt_held;
  logic [1:0] cnt_exp;
  logic [1:0] dcnt;

  assign b    = step.rx_byte;
  assign dcnt = mrsp_pkg::data_count(b);

  // Next parse state and the message this byte completes.
  always_comb begin
    run_nxt   = run_r;
    open_nxt  = open_r;
    held_nxt  = held_r;
    nheld_nxt = nheld_r;
    nexp_nxt  = nexp_r;
    res_valid = 1'b0;
    res_msg   = '0;
    st        = open_r;
    cnt_held  = nheld_r;
    cnt_exp   = nexp_r;

    if (b >= mrsp_pkg::RealtimeFirst) begin
      // Realtime bytes pass through and leave the parse alone.
      res_valid          = 1'b1;
      res_msg.msg_len    = mrsp_pkg::LenOne;
      res_msg.msg_status = b;
    end else if ((b & mrsp_pkg::StatusFlag) != 8'd0) begin
      if (b == mrsp_pkg::SysexStart || b == mrsp_pkg::SysexEnd) begin
        // Sysex framing clears everything.
        run_nxt   = '0;
        open_nxt  = '0;
        held_nxt  = '0;
        nheld_nxt = '0;
        nexp_nxt  = '0;
      end else begin
        // System common statuses cancel running status.
        run_nxt = (b >= mrsp_pkg::SysCommonLow) ? 8'd0 : b;
        if (dcnt == 2'd0) begin
          nheld_nxt          = '0;
          nexp_nxt           = '0;
          res_valid          = 1'b1;
          res_msg.msg_len    = mrsp_pkg::LenOne;
          res_msg.msg_status = b;
        end else begin
          open_nxt  = b;
          nheld_nxt = 2'd1;
          nexp_nxt  = dcnt + 2'd1;
        end
      end
    end else begin
      // Data byte: reopen under running status when no message is open.
      if (nheld_r == 2'd0 && run_r != 8'd0) begin
        st       = run_r;
        cnt_held = 2'd1;
        cnt_exp  = mrsp_pkg::data_count(run_r) + 2'd1;
      end
      if (cnt_held != 2'd0) begin
        open_nxt = st;
        nexp_nxt = cnt_exp;
        if (cnt_held == 2'd1) begin
          held_nxt = b[6:0];
          if (cnt_exp <= 2'd2) begin
            nheld_nxt          = 2'd0;
            res_valid          = 1'b1;
            res_msg.msg_len    = mrsp_pkg::LenTwo;
            res_msg.msg_status = st;
            res_msg.msg_data1  = b[6:0];
          end else begin
            nheld_nxt = 2'd2;
          end
        end else begin
          nheld_nxt          = 2'd0;
          res_valid          = 1'b1;
          res_msg.msg_len    = mrsp_pkg::LenThree;
          res_msg.msg_status = st;
          res_msg.msg_data1  = held_r;
          res_msg.msg_data2  = b[6:0];
        end
      end
    end
  end

  // State advances only when a byte is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      open_r  <= '0;
      held_r  <= '0;
      nheld_r <= '0;
      nexp_r  <= '0;
    end else if (step.fire) begin
      run_r   <= run_nxt;
      open_r  <= open_nxt;
      held_r  <= held_nxt;
      nheld_r <= nheld_nxt;
      nexp_r  <= nexp_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/mrsp_out_reg.sv
// Result register of the MIDI parser: holds one message until the sink takes it.
// Depends on mrsp_pkg for the message type.
`default_nettype none

module mrsp_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire mrsp_pkg::msg_t  load_msg,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output mrsp_pkg::msg_t       out_msg,
  output logic                 space
);

  logic           valid_r;
  logic           valid_nxt;
  mrsp_pkg::msg_t msg_r;

  // Room for a new message when empty or being drained this cycle.
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      msg_r <= load_msg;
    end
  end

  assign out_valid = valid_r;
  assign out_msg   = msg_r;

endmodule

`default_nettype wire

### rtl/midi_running_status_parser_unit.sv
// MIDI byte-stream parser with running status, top level.
// A byte is held in the input register, decoded by the parser and its message loaded into the result register.
// Throughput: one byte per cycle while the sink takes messages; set by the
// input register and result register, with the parse state updated in one step.
// Reset (rst_n low, synchronous) empties both registers and clears the parse state.
// Depends on mrsp_pkg, mrsp_if, mrsp_in_reg, mrsp_parser and mrsp_out_reg.
`default_nettype none

module midi_running_status_parser_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mrsp_in_if.sink     in_ch,
  mrsp_out_if.source  out_ch
);

  mrsp_pkg::step_t step;
  mrsp_pkg::msg_t  res_msg;
  mrsp_pkg::msg_t  out_msg;
  logic            res_valid;
  logic            space;
  logic            in_ready;
  logic            out_valid;

  // Input register.
  mrsp_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.rx_byte),
    .in_ready  (in_ready),
    .out_space (space),
    .step      (step)
  );

  // Parse state and decode.
  mrsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (res_valid),
    .res_msg   (res_msg)
  );

  // Result register.
  mrsp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step.fire && res_valid),
    .load_msg  (res_msg),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_msg   (out_msg),
    .space     (space)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.msg_len    = out_msg.msg_len;
  assign out_ch.msg_status = out_msg.msg_status;
  assign out_ch.msg_data1  = out_msg.msg_data1;
  assign out_ch.msg_data2  = out_msg.msg_data2;

endmodule

`default_nettype wire

### bench/midi_running_status_parser_unit_test.sv
// Self-checking testbench for the MIDI running-status parser: drives byte items, predicts
// messages with its own parser model and compares each message item field by field.
// Depends on mrsp_pkg, mrsp_if and midi_running_status_parser_unit.
`default_nettype none

// Parser model and store of expected messages.
class midi_msg_scoreboard;
  logic [7:0]     run_status;
  logic [7:0]     open_status;
  logic [6:0]     first_data;
  logic [1:0]     held;
  logic [1:0]     expected_len;
  mrsp_pkg::msg_t expected_msgs[$];
  int             errors;

  function new();
    clear_parse();
    errors = 0;
  endfunction

  function void clear_parse();
    run_status   = 8'h00;
    open_status  = 8'h00;
    first_data   = 7'h00;
    held         = 2'd0;
    expected_len = 2'd0;
  endfunction

  // Number of data bytes that a status byte calls for.
  function int data_bytes_after(logic [7:0] st);
    if (st >= mrsp_pkg::RealtimeFirst) return 0;
    if (st[7:4] == mrsp_pkg::NibProgram || st[7:4] == mrsp_pkg::NibPressure) return 1;
    if (st[7:4] != mrsp_pkg::NibSystem) return 2;
    if (st == mrsp_pkg::SongPosition) return 2;
    if (st == mrsp_pkg::SysCommonLow || st == mrsp_pkg::SongSelect) return 1;
    return 0;
  endfunction

  function void push_msg(logic [1:0] len, logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    mrsp_pkg::msg_t m;
    m.msg_len    = len;
    m.msg_status = st;
    m.msg_data1  = d1;
    m.msg_data2  = d2;
    expected_msgs.push_back(m);
  endfunction

  // Advance the model by one accepted byte item.
  function void note_byte(logic [7:0] b);
    int need;
    if (b >= mrsp_pkg::RealtimeFirst) begin
      push_msg(mrsp_pkg::LenOne, b, 7'h00, 7'h00);
      return;
    end
    if ((b & mrsp_pkg::StatusFlag) != 8'h00) begin
      if (b == mrsp_pkg::SysexStart || b == mrsp_pkg::SysexEnd) begin
        clear_parse();
        return;
      end
      // System common statuses cancel running status.
      run_status = (b >= mrsp_pkg::SysCommonLow) ? 8'h00 : b;
      need = 1 + data_bytes_after(b);
      if (need == 1) begin
        held = 2'd0;
        expected_len = 2'd0;
        push_msg(mrsp_pkg::LenOne, b, 7'h00, 7'h00);
        return;
      end
      open_status  = b;
      held         = 2'd1;
      expected_len = need[1:0];
      return;
    end
    // Data byte with nothing open: reopen under running status or drop it.
    if (held == 2'd0) begin
      if (run_status == 8'h00) return;
      open_status  = run_status;
      held         = 2'd1;
      need         = 1 + data_bytes_after(run_status);
      expected_len = need[1:0];
    end
    if (held == 2'd1) begin
      first_data = b[6:0];
      if (expected_len <= mrsp_pkg::LenTwo) begin
        held = 2'd0;
        push_msg(mrsp_pkg::LenTwo, open_status, b[6:0], 7'h00);
      end else begin
        held = 2'd2;
      end
      return;
    end
    held = 2'd0;
    push_msg(mrsp_pkg::LenThree, open_status, first_data, b[6:0]);
  endfunction

  task report(string what, int got, int want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Compare one accepted message item with the oldest expectation.
  task check_msg(mrsp_pkg::msg_t got);
    mrsp_pkg::msg_t want;
    if (expected_msgs.size() == 0) begin
      report("unexpected message, status", got.msg_status, 0);
      return;
    end
    want = expected_msgs.pop_front();
    if (got.msg_len !== want.msg_len) report("msg_len", got.msg_len, want.msg_len);
    if (got.msg_status !== want.msg_status) report("msg_status", got.msg_status, want.msg_status);
    if (got.msg_data1 !== want.msg_data1) report("msg_data1", got.msg_data1, want.msg_data1);
    if (got.msg_data2 !== want.msg_data2) report("msg_data2", got.msg_data2, want.msg_data2);
  endtask

  function int pending();
    return expected_msgs.size();
  endfunction
endclass

module midi_running_status_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit  = 5000;
  localparam int PhaseBytes  = 420;
  localparam int DrainCycles = 10;

  logic clk = 1'b0;
  logic rst_n;

  mrsp_in_if  in_ch();
  mrsp_out_if out_ch();

  midi_running_status_parser_unit DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  midi_msg_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;
  int quiet_cycles   = 0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: ready changes at the falling edge.
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: note accepted bytes, check accepted messages, watch for a hang.
  always @(posedge clk) begin
    mrsp_pkg::msg_t got;
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.msg_len    = out_ch.msg_len;
        got.msg_status = out_ch.msg_status;
        got.msg_data1  = out_ch.msg_data1;
        got.msg_data2  = out_ch.msg_data2;
        sb.check_msg(got);
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        sb.note_byte(in_ch.rx_byte);
      end
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one byte item, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_realtime();
    logic [2:0] low;
    low = 3'($urandom_range(7));
    send_byte({5'b11111, low});
  endtask

  // Random data bytes, now and then interleaved with a realtime byte.
  task automatic send_data(input int n);
    logic [6:0] d;
    repeat (n) begin
      if ($urandom_range(99) < 5) send_realtime();
      d = 7'($urandom_range(127));
      send_byte({1'b0, d});
    end
  endtask

  // One random burst: mostly well-formed messages, some broken ones and noise.
  task automatic send_random_burst();
    int         pick;
    int         cnt;
    logic [2:0] hi;
    logic [3:0] lo;
    logic [7:0] st;
    pick = int'($urandom_range(99));
    if (pick < 40) begin
      // Channel message followed by running-status repeats.
      hi = 3'($urandom_range(6));
      lo = 4'($urandom_range(15));
      st = {1'b1, hi, lo};
      cnt = sb.data_bytes_after(st);
      send_byte(st);
      send_data(cnt);
      repeat ($urandom_range(3)) send_data(cnt);
    end else if (pick < 50) begin
      // System common message, sometimes with stray data after it.
      hi = 3'($urandom_range(1, 6));
      st = {5'b11110, hi};
      send_byte(st);
      send_data(sb.data_bytes_after(st));
      if ($urandom_range(3) == 0) send_data(int'($urandom_range(1, 2)));
    end else if (pick < 58) begin
      // Sysex block; its payload is dropped.
      send_byte(mrsp_pkg::SysexStart);
      send_data(int'($urandom_range(4)));
      if ($urandom_range(3) != 0) send_byte(mrsp_pkg::SysexEnd);
    end else if (pick < 66) begin
      // Truncated channel message, cut off by whatever comes next.
      hi = 3'($urandom_range(6));
      lo = 4'($urandom_range(15));
      st = {1'b1, hi, lo};
      send_byte(st);
      cnt = sb.data_bytes_after(st);
      if (cnt > 1) send_data(1);
    end else if (pick < 74) begin
      send_data(int'($urandom_range(1, 3)));
    end else if (pick < 80) begin
      send_realtime();
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // Directed bytes: extremes, every kind of status and each special case.
  logic [7:0] directed_bytes[] = '{
    8'h7F,                          // data with no running status is dropped
    8'h90, 8'h00, 8'hFF, 8'h7F,     // note on, realtime byte inside it
    8'h01, 8'h02,                   // reuse of running status
    8'hC5, 8'h7F,                   // program change, one data byte
    8'hB0, 8'h01, 8'hE0, 8'h00, 8'h7F, // partial message dropped by a new status
    8'hF1, 8'h22, 8'h33,            // system common clears running status
    8'hF2, 8'h01, 8'h02,            // song position
    8'hF3, 8'h05,                   // song select
    8'hF4, 8'hF5, 8'hF6,            // statuses without data
    8'h80, 8'hF0, 8'h55, 8'hF7, 8'h10 // sysex clears all state
  };

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Random phases with different idle and stall pressure.
    for (int phase = 0; phase < 4; phase++) begin
      int phase_end;
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) send_random_burst();
    end

    @(negedge clk);
    in_ch.valid = 1'b0;

    // Drain the remaining messages, then give the pipeline time to show extras.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
